// ----- hdl/lskv_pkg.sv -----
// Shared constants for the linear-search key/value table.
// Request codes, result status codes, field widths and parameter defaults.
// No dependencies.
package lskv_pkg;

  // Parameter defaults
  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Port field widths
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

// ----- hdl/lskv_store.sv -----
// Key and value memories of the table: one write port, one registered read port.
// Depends on lskv_pkg for parameter defaults.
module lskv_store #(
  parameter int CAPACITY    = lskv_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = lskv_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lskv_pkg::VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [KEY_WIDTH-1:0]   wr_key,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [AW-1:0]          rd_addr,
  output logic [KEY_WIDTH-1:0]   rd_key,
  output logic [VALUE_WIDTH-1:0] rd_value
);

  logic [KEY_WIDTH-1:0]   key_mem   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  // Read data is registered: it lands in the cycle after the address
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

// ----- hdl/linear_search_key_value_table.sv -----
// Linear-search key/value table: top level with request sequencer and result register.
// Depends on lskv_pkg and lskv_store.
//
// Usage:
//   Input channel in_*: one request per handshake. in_tuser carries the action
//   (put, get, remove, clear); in_tdata carries the key and the value for put.
//   Result channel out_*: exactly one result per request, in request order,
//   giving found, read value, status and the entry count after the request.
//   The table is unsorted; entries 0..count-1 are scanned from index 0 upward,
//   one memory read per cycle through a single registered read port and one
//   key comparator.
//   A request that hits stops the scan at its key; a miss scans all entries,
//   and on an empty table goes straight to the decision. Clear skips the scan.
//   Remove with a hit adds a step to fetch the last entry that fills the hole.
//   The slowest request is a remove that hits the last entry of a full table.
//   in_tready is high only while the sequencer is idle: one request at a time.
//   The result register frees the sequencer, so a new request is taken while
//   an old result waits; with the receiver stalled the next result parks in
//   the sequencer and no further request is taken until the register drains.
//   Reset (rst_n low, synchronous) empties the table; memory contents are left
//   as they are, since only entries below the count are ever read.
module linear_search_key_value_table #(
  parameter int CAPACITY    = lskv_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = lskv_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lskv_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] lookup_key, [63:32] store_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] found, [32:1] read_value, [34:33] status,
                                  // [41:35] entry_count, [47:42] zero
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int KXW = (KEY_WIDTH > lskv_pkg::KEY_W) ? KEY_WIDTH : lskv_pkg::KEY_W;
  localparam int VXW = (VALUE_WIDTH > lskv_pkg::VALUE_W) ? VALUE_WIDTH : lskv_pkg::VALUE_W;
  localparam int NXW = (CW > lskv_pkg::COUNT_W) ? CW : lskv_pkg::COUNT_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [lskv_pkg::ACTION_W-1:0]   act_r, act_nxt;
  logic [KEY_WIDTH-1:0]            key_r, key_nxt;
  logic [VALUE_WIDTH-1:0]          val_r, val_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   issue_r, issue_nxt;   // next index to read
  logic                            pend_v_r, pend_v_nxt; // a read is in flight
  logic [AW-1:0]                   pend_idx_r, pend_idx_nxt;
  logic                            hit_r, hit_nxt;
  logic [AW-1:0]                   hit_idx_r, hit_idx_nxt;
  logic [VALUE_WIDTH-1:0]          rdv_r, rdv_nxt;
  logic [lskv_pkg::STATUS_W-1:0]   stat_r, stat_nxt;

  // Result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [lskv_pkg::VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [lskv_pkg::STATUS_W-1:0]   out_stat_r, out_stat_nxt;
  logic [lskv_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  // Memory port
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [AW-1:0]          rd_addr;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;

  logic [KXW-1:0] in_key_wide;
  logic [VXW-1:0] in_val_wide;
  logic [VXW-1:0] rdv_wide;
  logic [NXW-1:0] count_wide;
  logic [AW-1:0]  last_idx;
  logic           match;
  logic           last_pend;
  logic           in_fire;
  logic           out_free;

  lskv_store #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Keep only the low KEY_WIDTH / VALUE_WIDTH bits of the request fields
  assign in_key_wide = KXW'(in_tdata[31:0]);
  assign in_val_wide = VXW'(in_tdata[63:32]);

  assign last_idx  = AW'(count_r - CW'(1));
  assign match     = pend_v_r && (rd_key == key_r);
  assign last_pend = pend_v_r && (CW'(pend_idx_r) == count_r - CW'(1));

  assign rdv_wide   = VXW'(rdv_r);
  assign count_wide = NXW'(count_r);

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    count_nxt    = count_r;
    issue_nxt    = issue_r;
    pend_v_nxt   = 1'b0;
    pend_idx_nxt = pend_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    rdv_nxt      = rdv_r;
    stat_nxt     = stat_r;
    wr_en        = 1'b0;
    wr_addr      = hit_idx_r;
    wr_key       = key_r;
    wr_value     = val_r;
    rd_addr      = issue_r[AW-1:0];

    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    out_stat_nxt  = out_stat_r;
    out_count_nxt = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_tuser;
          key_nxt   = in_key_wide[KEY_WIDTH-1:0];
          val_nxt   = in_val_wide[VALUE_WIDTH-1:0];
          issue_nxt = '0;
          hit_nxt   = 1'b0;
          rdv_nxt   = '0;
          stat_nxt  = lskv_pkg::ST_OK;
          if (in_tuser == lskv_pkg::ACT_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      // One read issued per cycle; the compare trails the address, in the cycle after it
      S_SEARCH: begin
        if (issue_r < count_r) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = issue_r[AW-1:0];
          issue_nxt    = issue_r + CW'(1);
        end
        if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pend_idx_r;
          rdv_nxt     = rd_value;
          pend_v_nxt  = 1'b0;
          state_nxt   = S_DECIDE;
        end else if (last_pend) begin
          pend_v_nxt = 1'b0;
          state_nxt  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_DONE;
        case (act_r)
          lskv_pkg::ACT_PUT: begin
            rdv_nxt = '0;
            if (hit_r) begin
              wr_en = 1'b1;
            end else if (count_r < CW'(CAPACITY)) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
            end else begin
              stat_nxt = lskv_pkg::ST_FULL;
            end
          end
          lskv_pkg::ACT_GET: begin
            if (!hit_r) begin
              stat_nxt = lskv_pkg::ST_NOT_FOUND;
            end
          end
          lskv_pkg::ACT_REMOVE: begin
            rdv_nxt = '0;
            if (hit_r) begin
              rd_addr   = last_idx;  // fetch the last entry to fill the hole
              state_nxt = S_MOVE;
            end
          end
          default: begin
            rdv_nxt = '0;
          end
        endcase
      end

      S_MOVE: begin
        wr_en     = 1'b1;
        wr_key    = rd_key;
        wr_value  = rd_value;
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_value_nxt = rdv_wide[lskv_pkg::VALUE_W-1:0];
          out_stat_nxt  = stat_r;
          out_count_nxt = count_wide[lskv_pkg::COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    issue_r     <= issue_nxt;
    pend_idx_r  <= pend_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    rdv_r       <= rdv_nxt;
    stat_r      <= stat_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
    out_stat_r  <= out_stat_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_count_r, out_stat_r, out_value_r, out_found_r};

  // ---------------------------------------------------------------------------
  // Assertions

  // Once a request is taken the sequencer is busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while sequencer busy");

  // The entry count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A miss on get reports no hit and a zero value
  a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r == lskv_pkg::ST_NOT_FOUND) |->
      !out_found_r && (out_value_r == '0))
    else $error("not-found result carries data");

  // Memory writes happen only while deciding or moving an entry
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_DECIDE) || (state_r == S_MOVE))
    else $error("memory write outside update states");

endmodule
